@@ hw/rtl/nfc_host_frame_encoder_assert.svh @@
// Assertion macros shared by the frame encoder RTL.
`ifndef NFC_HOST_FRAME_ENCODER_ASSERT_SVH
`define NFC_HOST_FRAME_ENCODER_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define NFCHFE_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define NFCHFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/nfchfe_pkg.sv @@
// Types, constants and helper functions of the frame encoder.
package nfchfe_pkg;

   // Default depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Sequencer step codes within one command
   typedef logic [3:0] step_type;
   localparam step_type STEP_HEAD_FIRST     = 4'd0;
   localparam step_type STEP_HEAD_WAKE_LAST = 4'd1;
   localparam step_type STEP_HEAD_LAST      = 4'd8;
   localparam step_type STEP_LEN            = 4'd9;
   localparam step_type STEP_LCS            = 4'd10;
   localparam step_type STEP_DATA           = 4'd11;
   localparam step_type STEP_DCS            = 4'd12;
   localparam step_type STEP_POST           = 4'd13;

   // Byte constants of the frame
   localparam logic [7:0] BYTE_WAKE  = 8'h55;
   localparam logic [7:0] BYTE_START = 8'hFF;
   localparam logic [7:0] BYTE_ZERO  = 8'h00;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } rsp_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] len;
      logic [7:0] dcs;
      logic       first;
      logic       last;
   } cmd_type;

   // Queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Preamble and start code byte for a header step
   function automatic logic [7:0] header_byte(input step_type step);
      logic [7:0] result;
      unique case (step) inside
         STEP_HEAD_FIRST, STEP_HEAD_WAKE_LAST: result = BYTE_WAKE;
         STEP_HEAD_LAST:                       result = BYTE_START;
         default:                              result = BYTE_ZERO;
      endcase
      return result;
   endfunction

endpackage

@@ hw/rtl/nfchfe_front.sv @@
// Front end: accepts payload bytes, tracks frame position and checksum.
module nfchfe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  nfchfe_pkg::req_type req_item,
   input  nfchfe_pkg::qstat_type q_stat,
   output logic                cmd_push,
   output nfchfe_pkg::cmd_type cmd
);

   logic [7:0] rem_ff, rem_in;
   logic [7:0] sum_ff, sum_in;
   logic       first;
   logic [7:0] len_eff;
   logic [7:0] rem_base;
   logic [7:0] rem_after;
   logic [7:0] sum_after;

   // Accept whenever the queue has room
   assign full     = q_stat.full;
   assign cmd_push = push && !q_stat.full;

   // Classify the item against the current frame
   always_comb begin
      first     = (rem_ff == 8'd0);
      len_eff   = (req_item.frame_length == 8'd0) ? 8'd1 : req_item.frame_length;
      rem_base  = first ? len_eff : rem_ff;
      rem_after = rem_base - 8'd1;
      sum_after = (first ? 8'd0 : sum_ff) + req_item.data_byte;

      cmd.data_byte = req_item.data_byte;
      cmd.len       = len_eff;
      cmd.dcs       = 8'd0 - sum_after;
      cmd.first     = first;
      cmd.last      = (rem_after == 8'd0);

      rem_in = rem_ff;
      sum_in = sum_ff;
      if (cmd_push) begin
         rem_in = rem_after;
         sum_in = cmd.last ? 8'd0 : sum_after;
      end
   end

   // Hold frame position and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 8'd0;
         sum_ff <= 8'd0;
      end else begin
         rem_ff <= rem_in;
         sum_ff <= sum_in;
      end
   end

endmodule

@@ hw/rtl/nfchfe_queue.sv @@
// Short command queue between front and back.
module nfchfe_queue #(
   parameter int DEPTH = nfchfe_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  nfchfe_pkg::cmd_type   wr_cmd,
   input  logic                  rd_en,
   output nfchfe_pkg::cmd_type   rd_cmd,
   output nfchfe_pkg::qstat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   nfchfe_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign rd_cmd       = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

@@ hw/rtl/nfchfe_back.sv @@
// Back end: steps through each command and emits frame bytes one per cycle while each byte is popped.
module nfchfe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  nfchfe_pkg::cmd_type  cmd,
   output logic                 cmd_pop,
   output nfchfe_pkg::rsp_type  rsp_item,
   output logic                 empty,
   input  logic                 pop
);

   logic                 started_ff, started_in;
   nfchfe_pkg::step_type step_ff, step_in;
   logic                 out_valid_ff, out_valid_in;
   nfchfe_pkg::rsp_type  out_item_ff, out_item_in;
   nfchfe_pkg::step_type cur_step;
   nfchfe_pkg::step_type end_step;
   logic                 pop_ok;
   logic                 load;
   logic                 at_end;
   logic [7:0]           byte_sel;

   assign empty    = !out_valid_ff;
   assign rsp_item = out_item_ff;
   assign pop_ok   = pop && out_valid_ff;
   assign load     = cmd_valid && (!out_valid_ff || pop_ok);
   assign cmd_pop  = load && at_end;

   // Pick the step and the byte it produces
   always_comb begin
      if (started_ff) begin
         cur_step = step_ff;
      end else begin
         cur_step = cmd.first ? nfchfe_pkg::STEP_HEAD_FIRST : nfchfe_pkg::STEP_DATA;
      end
      end_step = cmd.last ? nfchfe_pkg::STEP_POST : nfchfe_pkg::STEP_DATA;
      at_end   = (cur_step == end_step);

      unique case (cur_step) inside
         [nfchfe_pkg::STEP_HEAD_FIRST:nfchfe_pkg::STEP_HEAD_LAST]:
            byte_sel = nfchfe_pkg::header_byte(cur_step);
         nfchfe_pkg::STEP_LEN:  byte_sel = cmd.len;
         nfchfe_pkg::STEP_LCS:  byte_sel = 8'd0 - cmd.len;
         nfchfe_pkg::STEP_DATA: byte_sel = cmd.data_byte;
         nfchfe_pkg::STEP_DCS:  byte_sel = cmd.dcs;
         default:               byte_sel = nfchfe_pkg::BYTE_ZERO;
      endcase
   end

   // Load the output register or drain it
   always_comb begin
      started_in   = started_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (load) begin
         started_in            = !at_end;
         step_in               = cur_step + 4'd1;
         out_valid_in          = 1'b1;
         out_item_in.out_byte  = byte_sel;
         out_item_in.run_last  = at_end;
         out_item_in.frame_end = (cur_step == nfchfe_pkg::STEP_POST);
      end else if (pop_ok) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         step_ff      <= nfchfe_pkg::STEP_HEAD_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

endmodule

@@ hw/rtl/nfc_host_frame_encoder.sv @@
// Frame encoder top level: front end, command queue and byte sequencer.
// The first result of an item passes through the command queue and the output register.
// One result per cycle while results are popped, from the byte sequencer's single output
// register; a frame's first and last items add header, checksum and postamble bytes.
// Input items enter at one per cycle until the command queue fills.
// Reset (synchronous, active high) empties queue and output, and starts between frames.
`include "nfc_host_frame_encoder_assert.svh"

module nfc_host_frame_encoder #(
   parameter int QUEUE_DEPTH = nfchfe_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  nfchfe_pkg::req_type req_item,
   output logic                empty,
   input  logic                pop,
   output nfchfe_pkg::rsp_type rsp_item
);

   nfchfe_pkg::cmd_type   cmd_wr;
   nfchfe_pkg::cmd_type   cmd_rd;
   nfchfe_pkg::qstat_type q_stat;
   logic                  cmd_push;
   logic                  cmd_pop;

   nfchfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .q_stat   (q_stat),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   nfchfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (cmd_push),
      .wr_cmd (cmd_wr),
      .rd_en  (cmd_pop),
      .rd_cmd (cmd_rd),
      .q_stat (q_stat)
   );

   nfchfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_stat.empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_item  (rsp_item),
      .empty     (empty),
      .pop       (pop)
   );

   // Queue never reports full and empty together
   `NFCHFE_ASSERT_HOLDS(a_q_status, clock, reset, !(q_stat.full && q_stat.empty), "queue full and empty")
   // Back end only retires a command that is present
   `NFCHFE_ASSERT_HOLDS(a_pop_present, clock, reset, !cmd_pop || !q_stat.empty, "pop on empty queue")
   // The closing byte is always the last result of its item
   `NFCHFE_ASSERT_HOLDS(a_end_last, clock, reset, empty || !rsp_item.frame_end || rsp_item.run_last, "frame end not last")
   // A command written to an empty queue is visible next cycle
   `NFCHFE_ASSERT_NEXT(a_q_fill, clock, reset, cmd_push && q_stat.empty, !q_stat.empty, "queue lost command")

endmodule
